/* rtl/core/skst_pkg.sv */
// shared types and constants for the sorted key set table
package skst_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_IN_W = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_LOCATE,
        S_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     capture;
    } t_cell_ctl;

endpackage

/* rtl/core/skst_cell.sv */
// one slot of the sorted table: holds a key and compares it against the search key
module skst_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  skst_pkg::t_cell_ctl i_ctl,
    input  logic                i_live,
    input  logic [KEY_BITS-1:0] i_search_key,
    input  logic [KEY_BITS-1:0] i_left_key,
    input  logic [KEY_BITS-1:0] i_right_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_lt,
    output logic                o_eq
);
    import skst_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic                r_lt;
    logic                r_eq;
    logic [KEY_BITS-1:0] n_key;

    always_comb begin
        case (i_ctl.op)
            CELL_SHIFT_UP:   n_key = i_left_key;
            CELL_SHIFT_DOWN: n_key = i_right_key;
            CELL_LOAD:       n_key = i_search_key;
            default:         n_key = r_key;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.capture) begin
            r_lt <= i_live && (r_key < i_search_key);
            r_eq <= i_live && (r_key == i_search_key);
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

/* rtl/core/skst_locate.sv */
// finds the lower-bound edge in the row of compare flags and encodes its index
module skst_locate #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic [CAPACITY-1:0] i_lt,
    input  logic [CAPACITY-1:0] i_eq,
    output logic [CNT_W-1:0]    o_pos,
    output logic                o_hit
);
    logic [CAPACITY-1:0] w_edge;
    logic [CNT_W-1:0]    w_enc;

    // edge sits on the first cell whose key is not below the search key
    always_comb begin
        w_edge[0] = !i_lt[0];
        for (int i = 1; i < CAPACITY; i++) begin
            w_edge[i] = i_lt[i-1] && !i_lt[i];
        end
    end

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_edge[i]) begin
                w_enc = w_enc | CNT_W'(i);
            end
        end
    end

    // all cells below the key: the table is full and the slot is past the end
    assign o_pos = i_lt[CAPACITY-1] ? CNT_W'(CAPACITY) : w_enc;
    assign o_hit = |(w_edge & i_eq);

endmodule

/* rtl/core/sorted_key_set_table.sv */
// top level of the sorted key set table
//
// Keeps up to CAPACITY distinct keys in ascending order, one key per cell in
// a row of compare cells, plus a live-entry count. Each input beat is an
// insert, delete or lookup of one key; each one yields exactly one output
// beat with the status (ok, duplicate, not found, full), the lower-bound
// position of the key and the entry count after the request. A request
// passes through the compare, locate and update states in order: every
// cell compares its key against the search key, the row of compare flags
// is reduced to the registered lower-bound position and hit flag, then all
// cells shift one place up or down together to open or close the slot
// while the result is written to the output register. The next request
// can be taken once the block is back in idle. The block takes one request
// at a time and raises o_in_stall while it works; a result waiting in the
// output register does not hold off the next request, only the final update
// step waits until the output is free.
// Key bits above KEY_BITS are ignored. Position and count come out in the
// low 7 bits. There is no clearing pass after reset; cells beyond the live
// count are never compared as live.
module sorted_key_set_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [skst_pkg::REQ_W-1:0]       i_req_type,
    input  logic [skst_pkg::KEY_IN_W-1:0]    i_key,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [skst_pkg::STATUS_W-1:0]    o_status,
    output logic [skst_pkg::OUT_W-1:0]       o_position,
    output logic [skst_pkg::OUT_W-1:0]       o_entry_count
);
    import skst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KB_IN = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;

    // fsm and request registers
    t_state              r_state;
    t_state              n_state;
    t_req                r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    r_pos;
    logic                r_hit;

    // output register
    logic                r_out_valid;
    t_status             r_status;
    logic [OUT_W-1:0]    r_position;
    logic [OUT_W-1:0]    r_entry_count;

    logic [KEY_BITS-1:0] w_key_in;
    logic                w_accept;
    logic                w_out_free;
    logic                w_finish;
    logic                w_do_insert;
    logic                w_do_delete;
    t_status             w_status;

    // cell row wiring
    logic [KEY_BITS-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_live;
    t_cell_ctl           w_ctl      [CAPACITY];
    logic [CNT_W-1:0]    w_pos;
    logic                w_hit;

    // drop key bits above KEY_BITS, widen when KEY_BITS exceeds the port
    assign w_key_in   = KEY_BITS'(i_key[KB_IN-1:0]);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_UPDATE) && w_out_free;

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_COMPARE;
            S_COMPARE: n_state = S_LOCATE;
            S_LOCATE:  n_state = S_UPDATE;
            S_UPDATE:  if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // request outcome, unused request code behaves as a lookup
    always_comb begin
        w_do_insert = 1'b0;
        w_do_delete = 1'b0;
        case (r_req)
            REQ_INSERT: begin
                if (r_hit) begin
                    w_status = ST_DUP;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_status    = ST_OK;
                    w_do_insert = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (r_hit) begin
                    w_status    = ST_OK;
                    w_do_delete = 1'b1;
                end else begin
                    w_status = ST_MISSING;
                end
            end
            default: w_status = r_hit ? ST_OK : ST_MISSING;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_finish && w_do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_finish && w_do_delete) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // fsm outputs: stall and per-cell control
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i].capture = (r_state == S_COMPARE);
            w_ctl[i].op      = CELL_HOLD;
            if (w_finish && w_do_insert) begin
                if (CNT_W'(i) == r_pos) begin
                    w_ctl[i].op = CELL_LOAD;
                end else if (CNT_W'(i) > r_pos) begin
                    w_ctl[i].op = CELL_SHIFT_UP;
                end
            end else if (w_finish && w_do_delete) begin
                if (CNT_W'(i) >= r_pos) begin
                    w_ctl[i].op = CELL_SHIFT_DOWN;
                end
            end
        end
    end

    // row of cells, each talks to its two neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_left;
        logic [KEY_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = r_key;
        end else begin : g_mid_l
            assign w_left = w_cell_key[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_key[g];
        end else begin : g_mid_r
            assign w_right = w_cell_key[g+1];
        end

        assign w_live[g] = CNT_W'(g) < r_count;

        skst_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_live      (w_live[g]),
            .i_search_key(r_key),
            .i_left_key  (w_left),
            .i_right_key (w_right),
            .o_key       (w_cell_key[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g])
        );
    end

    skst_locate #(
        .CAPACITY(CAPACITY),
        .CNT_W   (CNT_W)
    ) u_locate (
        .i_lt (w_lt),
        .i_eq (w_eq),
        .o_pos(w_pos),
        .o_hit(w_hit)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_req_type);
            r_key <= w_key_in;
        end
        if (r_state == S_LOCATE) begin
            r_pos <= w_pos;
            r_hit <= w_hit;
        end
        if (w_finish) begin
            r_status      <= w_status;
            r_position    <= OUT_W'(r_pos);
            r_entry_count <= OUT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

endmodule

/* rtl/core/skst_check.sv */
// port-level assertions for the sorted key set table and their bind
module skst_check #(
    parameter int CAPACITY = 64
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [skst_pkg::STATUS_W-1:0]    o_status,
    input logic [skst_pkg::OUT_W-1:0]       o_position,
    input logic [skst_pkg::OUT_W-1:0]       o_entry_count
);
    import skst_pkg::*;

    localparam logic FITS = (CAPACITY < (1 << OUT_W));

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request beat taken while busy");

    // full status only when the table really holds capacity keys
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) && FITS |->
            (o_entry_count == OUT_W'(CAPACITY)))
        else $error("table full reported below capacity");

    // the slot never lies beyond the live entries
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && FITS |-> (o_position <= o_entry_count))
        else $error("position past entry count");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_position)
            && $stable(o_entry_count))
        else $error("stalled result beat changed");

endmodule

bind sorted_key_set_table skst_check #(.CAPACITY(CAPACITY)) u_skst_check (.*);
